/* hw/rtl/hpt_pkg.sv */
// Shared widths, register codes and pipeline types for the homogeneous point transform.
// Used by every module of the block; it depends on nothing else.
`default_nettype none
package hpt_pkg;

  localparam int CW     = 20;             // coefficient width, signed Q8.12
  localparam int PW     = 32;             // point coordinate width, signed Q16.16
  localparam int COLW   = 3 * CW;         // one matrix column register
  localparam int PRODW  = PW + CW;        // product width
  localparam int SW     = 54;             // signed row sum width
  localparam int MW     = SW - 1;         // row sum magnitude width
  localparam int FRAC   = 16;             // fraction bits of the result
  localparam int QW     = 32;             // quotient width
  localparam int NSTAGE = QW;             // one quotient bit per divider stage
  localparam int QDEPTH = 2;
  localparam int QAW    = 1;
  localparam int AW     = 5;
  localparam int DW     = 64;

  localparam logic [1:0] REG_COL0 = 2'd0;
  localparam logic [1:0] REG_COL1 = 2'd1;
  localparam logic [1:0] REG_COL2 = 2'd2;

  localparam logic [COLW-1:0] COL0_RST = COLW'(64'd4096);
  localparam logic [COLW-1:0] COL1_RST = COLW'(64'd4294967296);
  localparam logic [COLW-1:0] COL2_RST = COLW'(64'd4503599627370496);

  localparam logic [QW-1:0] POS_LIMIT = 32'h7fff_ffff;
  localparam logic [QW-1:0] NEG_LIMIT = 32'h8000_0000;

  typedef struct packed {
    logic [MW-1:0] num_x;
    logic [MW-1:0] num_y;
    logic [MW-1:0] den;
    logic          neg_x;
    logic          neg_y;
    logic          w_zero;
  } hpt_cmd_t;

  typedef struct packed {
    logic [MW-1:0] rem;
    logic [QW-1:0] low;
    logic [QW-1:0] quo;
    logic          neg;
    logic          ovf;
  } hpt_lane_t;

  typedef struct packed {
    hpt_lane_t     x;
    hpt_lane_t     y;
    logic [MW-1:0] den;
    logic          w_zero;
  } hpt_stage_t;

endpackage
`default_nettype wire

/* hw/rtl/hpt_front.sv */
// Front end: takes a point, forms the three homogeneous row sums and their magnitudes.
// Depends on hpt_pkg; feeds hpt_queue.
`default_nettype none
module hpt_front (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      acc,
  input  wire logic signed [hpt_pkg::PW-1:0]   point_x,
  input  wire logic signed [hpt_pkg::PW-1:0]   point_y,
  input  wire logic [hpt_pkg::COLW-1:0]  col0,
  input  wire logic [hpt_pkg::COLW-1:0]  col1,
  input  wire logic [hpt_pkg::COLW-1:0]  col2,
  output logic                           cmd_valid,
  output hpt_pkg::hpt_cmd_t              cmd
);

  logic signed [hpt_pkg::PRODW-1:0] pa_nxt [3];
  logic signed [hpt_pkg::PRODW-1:0] pb_nxt [3];
  logic signed [hpt_pkg::PRODW-1:0] pa_r   [3];
  logic signed [hpt_pkg::PRODW-1:0] pb_r   [3];
  logic signed [hpt_pkg::CW-1:0]    off_r  [3];
  logic signed [hpt_pkg::SW-1:0]    sum_r  [3];
  logic [hpt_pkg::MW-1:0]           mag_nxt [3];
  logic                             v1_r, v2_r, v3_r;
  hpt_pkg::hpt_cmd_t                cmd_r;

  for (genvar r = 0; r < 3; r++) begin : g_row
    logic signed [hpt_pkg::CW-1:0] ca, cb;
    assign ca = col0[r*hpt_pkg::CW +: hpt_pkg::CW];
    assign cb = col1[r*hpt_pkg::CW +: hpt_pkg::CW];
    assign pa_nxt[r] = ca * point_x;
    assign pb_nxt[r] = cb * point_y;
    assign mag_nxt[r] = sum_r[r][hpt_pkg::SW-1] ? hpt_pkg::MW'(-sum_r[r])
                                                : hpt_pkg::MW'(sum_r[r]);

    always_ff @(posedge clk) begin
      pa_r[r]  <= pa_nxt[r];
      pb_r[r]  <= pb_nxt[r];
      off_r[r] <= col2[r*hpt_pkg::CW +: hpt_pkg::CW];
      sum_r[r] <= hpt_pkg::SW'(pa_r[r]) + hpt_pkg::SW'(pb_r[r])
                + (hpt_pkg::SW'(off_r[r]) <<< hpt_pkg::FRAC);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= acc;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r.num_x  <= mag_nxt[0];
    cmd_r.num_y  <= mag_nxt[1];
    cmd_r.den    <= mag_nxt[2];
    cmd_r.neg_x  <= sum_r[0][hpt_pkg::SW-1] ^ sum_r[2][hpt_pkg::SW-1];
    cmd_r.neg_y  <= sum_r[1][hpt_pkg::SW-1] ^ sum_r[2][hpt_pkg::SW-1];
    cmd_r.w_zero <= (sum_r[2] == '0);
  end

  assign cmd_valid = v3_r;
  assign cmd       = cmd_r;

endmodule
`default_nettype wire

/* hw/rtl/hpt_queue.sv */
// Two-entry request queue between the front end and the divider back end.
// Depends on hpt_pkg for the request type.
`default_nettype none
module hpt_queue (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  input  wire hpt_pkg::hpt_cmd_t  wdata,
  input  wire logic               pop,
  output logic                    not_empty,
  output logic                    full,
  output hpt_pkg::hpt_cmd_t       rdata
);

  hpt_pkg::hpt_cmd_t          mem [hpt_pkg::QDEPTH];
  logic [hpt_pkg::QAW-1:0]    wptr_r, rptr_r;
  logic [hpt_pkg::QAW:0]      cnt_r, cnt_nxt;
  logic                       do_pop;

  assign not_empty = (cnt_r != '0);
  assign full      = (cnt_r == (hpt_pkg::QAW+1)'(hpt_pkg::QDEPTH));
  assign do_pop    = pop && not_empty;
  assign rdata     = mem[rptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wptr_r <= wptr_r + 1'b1;
      end
      if (do_pop) begin
        rptr_r <= rptr_r + 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/hpt_back.sv */
// Back end: pipelined restoring divider, one quotient bit per stage, then clamping and sign.
// Depends on hpt_pkg; drains hpt_queue and drives the result ports.
`default_nettype none
module hpt_back (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       cmd_valid,
  input  wire hpt_pkg::hpt_cmd_t          cmd,
  output logic                            out_valid,
  output logic signed [hpt_pkg::QW-1:0]   out_x,
  output logic signed [hpt_pkg::QW-1:0]   out_y,
  output logic                            out_w_zero,
  output logic                            out_saturated
);

  hpt_pkg::hpt_stage_t st_r [hpt_pkg::NSTAGE+1];
  logic                v_r  [hpt_pkg::NSTAGE+1];
  hpt_pkg::hpt_stage_t st0_nxt;
  logic                ov_r;
  logic [hpt_pkg::QW-1:0] ox_r, oy_r;
  logic                owz_r, osat_r;

  function automatic hpt_pkg::hpt_lane_t lane_init(input logic [hpt_pkg::MW-1:0] num,
                                                    input logic [hpt_pkg::MW-1:0] den,
                                                    input logic neg);
    hpt_pkg::hpt_lane_t l;
    l.rem = num >> hpt_pkg::FRAC;
    l.low = {num[hpt_pkg::FRAC-1:0], {(hpt_pkg::QW-hpt_pkg::FRAC){1'b0}}};
    l.quo = '0;
    l.neg = neg;
    l.ovf = {{hpt_pkg::FRAC{1'b0}}, num} >= {den, {hpt_pkg::FRAC{1'b0}}};
    return l;
  endfunction

  function automatic hpt_pkg::hpt_lane_t lane_step(input hpt_pkg::hpt_lane_t l,
                                                    input logic [hpt_pkg::MW-1:0] den);
    hpt_pkg::hpt_lane_t   n;
    logic [hpt_pkg::MW:0] trial;
    n     = l;
    trial = {l.rem, l.low[hpt_pkg::QW-1]} - {1'b0, den};
    n.low = l.low << 1;
    if (!trial[hpt_pkg::MW]) begin
      n.rem = trial[hpt_pkg::MW-1:0];
      n.quo = {l.quo[hpt_pkg::QW-2:0], 1'b1};
    end else begin
      n.rem = {l.rem[hpt_pkg::MW-2:0], l.low[hpt_pkg::QW-1]};
      n.quo = {l.quo[hpt_pkg::QW-2:0], 1'b0};
    end
    return n;
  endfunction

  function automatic logic lane_sat(input hpt_pkg::hpt_lane_t l);
    return l.ovf || (l.neg ? (l.quo[hpt_pkg::QW-1] && (|l.quo[hpt_pkg::QW-2:0]))
                           : l.quo[hpt_pkg::QW-1]);
  endfunction

  function automatic logic [hpt_pkg::QW-1:0] lane_val(input hpt_pkg::hpt_lane_t l);
    logic [hpt_pkg::QW-1:0] v;
    if (lane_sat(l)) begin
      v = l.neg ? hpt_pkg::NEG_LIMIT : hpt_pkg::POS_LIMIT;
    end else begin
      v = l.neg ? -l.quo : l.quo;
    end
    return v;
  endfunction

  always_comb begin
    st0_nxt.x      = lane_init(cmd.num_x, cmd.den, cmd.neg_x);
    st0_nxt.y      = lane_init(cmd.num_y, cmd.den, cmd.neg_y);
    st0_nxt.den    = cmd.den;
    st0_nxt.w_zero = cmd.w_zero;
  end

  always_ff @(posedge clk) begin
    st_r[0] <= st0_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else begin
      v_r[0] <= cmd_valid;
    end
  end

  for (genvar k = 0; k < hpt_pkg::NSTAGE; k++) begin : g_stage
    always_ff @(posedge clk) begin
      st_r[k+1].x      <= lane_step(st_r[k].x, st_r[k].den);
      st_r[k+1].y      <= lane_step(st_r[k].y, st_r[k].den);
      st_r[k+1].den    <= st_r[k].den;
      st_r[k+1].w_zero <= st_r[k].w_zero;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k+1] <= 1'b0;
      end else begin
        v_r[k+1] <= v_r[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else begin
      ov_r <= v_r[hpt_pkg::NSTAGE];
    end
  end

  always_ff @(posedge clk) begin
    if (st_r[hpt_pkg::NSTAGE].w_zero) begin
      ox_r   <= '0;
      oy_r   <= '0;
      osat_r <= 1'b0;
    end else begin
      ox_r   <= lane_val(st_r[hpt_pkg::NSTAGE].x);
      oy_r   <= lane_val(st_r[hpt_pkg::NSTAGE].y);
      osat_r <= lane_sat(st_r[hpt_pkg::NSTAGE].x) || lane_sat(st_r[hpt_pkg::NSTAGE].y);
    end
    owz_r <= st_r[hpt_pkg::NSTAGE].w_zero;
  end

  assign out_valid     = ov_r;
  assign out_x         = ox_r;
  assign out_y         = oy_r;
  assign out_w_zero    = owz_r;
  assign out_saturated = osat_r;

endmodule
`default_nettype wire

/* hw/rtl/homogeneous_point_transform.sv */
// Top level of the homogeneous 2D point transform: matrix registers, front end, queue, divider.
// Depends on hpt_pkg, hpt_front, hpt_queue and hpt_back.
//
// One point is taken every clock while busy is low. Its result is marked by out_valid for one
// cycle; the receiver cannot stall it. The divider resolves one quotient bit per pipeline
// stage over 32 stages.
// The user must write the matrix over the register port only while no request is in flight;
// the block itself does not enforce this.
`default_nettype none
module homogeneous_point_transform (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  output logic                           busy,
  input  wire logic signed [hpt_pkg::PW-1:0]   in_point_x,
  input  wire logic signed [hpt_pkg::PW-1:0]   in_point_y,
  output logic                           out_valid,
  output logic signed [hpt_pkg::QW-1:0]  out_x,
  output logic signed [hpt_pkg::QW-1:0]  out_y,
  output logic                           out_w_zero,
  output logic                           out_saturated,
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic [hpt_pkg::AW-1:0]    paddr,
  input  wire logic [hpt_pkg::DW-1:0]    pwdata,
  output logic [hpt_pkg::DW-1:0]         prdata,
  output logic                           pready
);

  logic [hpt_pkg::COLW-1:0] col0_r, col1_r, col2_r;
  logic [1:0]               reg_idx;
  logic                     wr_en;
  logic                     acc;
  logic                     f_valid, q_full, q_ne;
  hpt_pkg::hpt_cmd_t        f_cmd, q_cmd;

  assign pready  = 1'b1;
  assign reg_idx = paddr[hpt_pkg::AW-1:3];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col0_r <= hpt_pkg::COL0_RST;
      col1_r <= hpt_pkg::COL1_RST;
      col2_r <= hpt_pkg::COL2_RST;
    end else if (wr_en) begin
      case (reg_idx)
        hpt_pkg::REG_COL0: col0_r <= pwdata[hpt_pkg::COLW-1:0];
        hpt_pkg::REG_COL1: col1_r <= pwdata[hpt_pkg::COLW-1:0];
        hpt_pkg::REG_COL2: col2_r <= pwdata[hpt_pkg::COLW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      hpt_pkg::REG_COL0: prdata = hpt_pkg::DW'(col0_r);
      hpt_pkg::REG_COL1: prdata = hpt_pkg::DW'(col1_r);
      hpt_pkg::REG_COL2: prdata = hpt_pkg::DW'(col2_r);
      default:           prdata = '0;
    endcase
  end

  assign busy = q_full;
  assign acc  = start && !busy;

  hpt_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (acc),
    .point_x   (in_point_x),
    .point_y   (in_point_y),
    .col0      (col0_r),
    .col1      (col1_r),
    .col2      (col2_r),
    .cmd_valid (f_valid),
    .cmd       (f_cmd)
  );

  hpt_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (f_valid),
    .wdata     (f_cmd),
    .pop       (q_ne),
    .not_empty (q_ne),
    .full      (q_full),
    .rdata     (q_cmd)
  );

  hpt_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd_valid     (q_ne),
    .cmd           (q_cmd),
    .out_valid     (out_valid),
    .out_x         (out_x),
    .out_y         (out_y),
    .out_w_zero    (out_w_zero),
    .out_saturated (out_saturated)
  );

endmodule
`default_nettype wire

/* hw/rtl/hpt_checker.sv */
// Port-level checks for the homogeneous point transform, bound to its top level.
// Depends on hpt_pkg and homogeneous_point_transform.
`default_nettype none
module hpt_checker (
  input wire logic                      clk,
  input wire logic                      rst_n,
  input wire logic                      busy,
  input wire logic                      out_valid,
  input wire logic [hpt_pkg::QW-1:0]    out_x,
  input wire logic [hpt_pkg::QW-1:0]    out_y,
  input wire logic                      out_w_zero,
  input wire logic                      out_saturated
);

  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("block refused a request");

  a_wzero_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_w_zero |-> out_x == '0 && out_y == '0 && !out_saturated)
    else $error("zero w result carries data");

  a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_saturated |->
      out_x == hpt_pkg::POS_LIMIT || out_x == hpt_pkg::NEG_LIMIT ||
      out_y == hpt_pkg::POS_LIMIT || out_y == hpt_pkg::NEG_LIMIT)
    else $error("saturated result without a clamped coordinate");

  a_reset_quiet: assert property (@(posedge clk) !$past(rst_n) |-> !out_valid)
    else $error("result right after reset");

endmodule

bind homogeneous_point_transform hpt_checker u_hpt_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .busy          (busy),
  .out_valid     (out_valid),
  .out_x         (out_x),
  .out_y         (out_y),
  .out_w_zero    (out_w_zero),
  .out_saturated (out_saturated)
);
`default_nettype wire

/* verif/homogeneous_point_transform_test.sv */
// Self-checking testbench for the homogeneous 2D point transform, predicting each result.
// Depends on hpt_pkg and homogeneous_point_transform, and through it on hpt_front, hpt_queue and hpt_back.
`default_nettype none

class hpt_scoreboard;
  typedef struct {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic               wz;
    logic               sat;
  } point_result_t;

  logic [hpt_pkg::COLW-1:0] col[3];
  point_result_t            pending[$];
  int                       errors;

  function new();
    col[0] = hpt_pkg::COL0_RST;
    col[1] = hpt_pkg::COL1_RST;
    col[2] = hpt_pkg::COL2_RST;
    errors = 0;
  endfunction

  function void set_column(int idx, logic [hpt_pkg::COLW-1:0] value);
    if (idx < 3) col[idx] = value;
  endfunction

  function longint coef(int c, int r);
    logic signed [hpt_pkg::CW-1:0] v;
    v = col[c][hpt_pkg::CW*r +: hpt_pkg::CW];
    return longint'(v);
  endfunction

  function logic [31:0] quotient(longint n, longint d, ref logic sat);
    bit        neg;
    bit [127:0] un, ud, mag, limit;
    neg   = (n < 0) != (d < 0);
    un    = (n < 0) ? 128'(-n) : 128'(n);
    ud    = (d < 0) ? 128'(-d) : 128'(d);
    mag   = (un << 16) / ud;
    limit = neg ? 128'h8000_0000 : 128'h7fff_ffff;
    if (mag > limit) begin
      sat = 1'b1;
      mag = limit;
    end
    return neg ? -mag[31:0] : mag[31:0];
  endfunction

  function void note_request(logic signed [31:0] x, logic signed [31:0] y);
    longint        sum[3];
    point_result_t e;
    for (int r = 0; r < 3; r++)
      sum[r] = coef(0, r) * longint'(x) + coef(1, r) * longint'(y) + coef(2, r) * 65536;
    e.sat = 1'b0;
    if (sum[2] == 0) begin
      e.px = 0;
      e.py = 0;
      e.wz = 1'b1;
    end else begin
      e.wz = 1'b0;
      e.px = quotient(sum[0], sum[2], e.sat);
      e.py = quotient(sum[1], sum[2], e.sat);
    end
    pending.push_back(e);
  endfunction

  function void check_result(logic signed [31:0] x, logic signed [31:0] y, logic wz, logic sat);
    point_result_t e;
    if (pending.size() == 0) begin
      $error("unexpected result out_x %0d out_y %0d", x, y);
      errors++;
      return;
    end
    e = pending.pop_front();
    if (x !== e.px) begin
      $error("out_x expected %0d got %0d", e.px, x);
      errors++;
    end
    if (y !== e.py) begin
      $error("out_y expected %0d got %0d", e.py, y);
      errors++;
    end
    if (wz !== e.wz) begin
      $error("out_w_zero expected %0b got %0b", e.wz, wz);
      errors++;
    end
    if (sat !== e.sat) begin
      $error("out_saturated expected %0b got %0b", e.sat, sat);
      errors++;
    end
  endfunction
endclass

module homogeneous_point_transform_test;

  localparam logic [1:0] REG_SPARE = 2'd3;

  logic                          clk;
  logic                          rst_n;
  logic                          start;
  logic                          busy;
  logic signed [hpt_pkg::PW-1:0] in_point_x;
  logic signed [hpt_pkg::PW-1:0] in_point_y;
  logic                          out_valid;
  logic signed [hpt_pkg::QW-1:0] out_x;
  logic signed [hpt_pkg::QW-1:0] out_y;
  logic                          out_w_zero;
  logic                          out_saturated;
  logic                          psel;
  logic                          penable;
  logic                          pwrite;
  logic [hpt_pkg::AW-1:0]        paddr;
  logic [hpt_pkg::DW-1:0]        pwdata;
  logic [hpt_pkg::DW-1:0]        prdata;
  logic                          pready;

  hpt_scoreboard sb = new();
  int            idle_pct;

  homogeneous_point_transform DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_point_x(in_point_x), .in_point_y(in_point_y),
    .out_valid(out_valid), .out_x(out_x), .out_y(out_y),
    .out_w_zero(out_w_zero), .out_saturated(out_saturated),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_result(out_x, out_y, out_w_zero, out_saturated);
  end

  task automatic wait_drained();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (45) @(posedge clk);
  endtask

  task automatic write_column(logic [1:0] idx, logic [hpt_pkg::COLW-1:0] value);
    logic [hpt_pkg::DW-1:0] rd;
    wait_drained();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= hpt_pkg::AW'(idx) << 3;
    pwdata  <= hpt_pkg::DW'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    sb.set_column(int'(idx), value);
    if (idx == REG_SPARE) begin
      psel    <= 1'b0;
      penable <= 1'b0;
      return;
    end
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    rd = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (rd[hpt_pkg::COLW-1:0] !== value) begin
      $error("prdata expected %0h got %0h", value, rd[hpt_pkg::COLW-1:0]);
      sb.errors++;
    end
  endtask

  task automatic load_matrix(logic [hpt_pkg::COLW-1:0] c0, logic [hpt_pkg::COLW-1:0] c1,
                             logic [hpt_pkg::COLW-1:0] c2);
    write_column(hpt_pkg::REG_COL0, c0);
    write_column(hpt_pkg::REG_COL1, c1);
    write_column(hpt_pkg::REG_COL2, c2);
  endtask

  task automatic send_point(logic signed [hpt_pkg::PW-1:0] x, logic signed [hpt_pkg::PW-1:0] y);
    start      <= 1'b1;
    in_point_x <= x;
    in_point_y <= y;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_request(x, y);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
  endtask

  task automatic stop_sending();
    start <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [hpt_pkg::CW-1:0] rand_coef();
    case ($urandom_range(5))
      0: return 20'h80000;
      1: return 20'h7ffff;
      2: return hpt_pkg::CW'($urandom);
      default: return hpt_pkg::CW'($urandom_range(8192) - 4096);
    endcase
  endfunction

  function automatic logic [hpt_pkg::COLW-1:0] rand_column(bit zero_w);
    logic [hpt_pkg::CW-1:0] r2;
    r2 = zero_w ? '0 : rand_coef();
    return {r2, rand_coef(), rand_coef()};
  endfunction

  function automatic logic signed [hpt_pkg::PW-1:0] rand_coord();
    case ($urandom_range(3))
      0: return hpt_pkg::PW'($urandom);
      1: return 0;
      default: return hpt_pkg::PW'($urandom_range(2_097_152) - 1_048_576);
    endcase
  endfunction

  initial begin
    int x_ext[6];
    rst_n      = 1'b0;
    start      = 1'b0;
    in_point_x = '0;
    in_point_y = '0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    idle_pct   = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed points through the identity matrix left by reset.
    x_ext = '{0, 1, -1, 32'h7fffffff, 32'h80000000, 32'h00010000};
    foreach (x_ext[i]) send_point(x_ext[i], x_ext[5 - i]);
    stop_sending();

    // Extreme coefficients, zero w row, tiny w for saturation, ignored spare register.
    load_matrix({3{20'h80000}}, {3{20'h7ffff}}, {20'h00001, 20'h7ffff, 20'h80000});
    write_column(REG_SPARE, {3{20'h12345}});
    foreach (x_ext[i]) send_point(x_ext[i], x_ext[i]);
    send_point(32'h7fffffff, 32'h80000000);
    stop_sending();
    load_matrix({20'h00000, 20'h00000, 20'h01000}, {20'h00000, 20'h01000, 20'h00000},
                {20'h00000, 20'h00000, 20'h00000});
    send_point(32'h00050000, -32'sh00030000);
    send_point(0, 0);
    stop_sending();
    load_matrix({20'h00000, 20'h00000, 20'h7ffff}, {20'h00000, 20'h80000, 20'h00000},
                {20'h00001, 20'h00000, 20'h00000});
    send_point(32'h7fffffff, 32'h00000000);
    send_point(32'h80000000, 32'h7fffffff);
    send_point(32'h00000001, 32'h00000001);
    send_point(0, 0);
    stop_sending();

    // Random phases with varied matrices and sender idling.
    for (int p = 0; p < 6; p++) begin
      case (p % 4)
        0: idle_pct = 0;
        1: idle_pct = 68;
        2: idle_pct = 0;
        default: idle_pct = 14;
      endcase
      if (p == 5) load_matrix({3{20'h80000}}, {3{20'h7ffff}}, {3{20'h7ffff}});
      else load_matrix(rand_column(p == 3), rand_column(p == 3), rand_column(p == 3));
      for (int i = 0; i < 238; i++) begin
        if (p == 2 && i == 120) begin
          stop_sending();
          while (sb.pending.size() != 0) @(posedge clk);
        end
        send_point(rand_coord(), rand_coord());
      end
      stop_sending();
    end

    wait_drained();
    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire
